[hw/rtl/ntlp_pkg.sv]
package ntlp_pkg;

   localparam int MINUTE_FRACTION_DIGITS = 4;
   localparam int FIELD_MAX_CHARS = 9;

   localparam int CHAR_W = 8;
   localparam int FIELD_W = 4;
   localparam int UTC_W = 28;
   localparam int LAT_W = 31;
   localparam int TIME_ACC_W = 28;
   localparam int DEG_W = 7;
   localparam int MIN_W = 20;
   localparam int FRAC_W = 3;
   localparam int DIGIT_W = 4;
   localparam int Q_W = 30;
   localparam int R_W = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [UTC_W-1:0] TIME_MAX = 28'd235959999;
   localparam logic [TIME_ACC_W-1:0] TIME_ACC_MAX = '1;
   localparam logic [MIN_W-1:0] MIN_ACC_MAX = '1;
   localparam logic [DEG_W-1:0] DEG_MAX = '1;
   localparam logic [LAT_W-1:0] LAT_MAX = 31'd900000000;
   localparam logic [Q_W-1:0] Q_MAX = '1;
   localparam logic [23:0] DEG_SCALE = 24'd10000000;
   localparam logic [FIELD_W-1:0] FIELD_LAST = '1;

   localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SOUTH = 8'h53;

   // Lane j holds minutes times 10^(7-j) as a quotient and remainder by 60.
   // These give 10^(7-j) split the same way.
   localparam logic [Q_W-1:0] LANE_Q [8] = '{
      30'd166666, 30'd16666, 30'd1666, 30'd166, 30'd16, 30'd1, 30'd0, 30'd0
   };
   localparam logic [R_W-1:0] LANE_R [8] = '{
      6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd10, 6'd1
   };

   // Converted minutes when the minute accumulator has saturated, by fraction digit count.
   localparam logic [Q_W-1:0] SAT_Q [8] = '{
      Q_MAX, Q_MAX, Q_MAX, 30'd174762500, 30'd17476250, 30'd1747625, Q_MAX, Q_MAX
   };

   localparam logic [9:0] POW10_3 [4] = '{10'd1, 10'd10, 10'd100, 10'd1000};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_FIELD = 1'b0,
      CSR_LAT_FIELD  = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [TIME_ACC_W-1:0] time_acc;
      logic [FRAC_W-1:0]     frac_seen;
      logic [DEG_W-1:0]      deg;
      logic                  min_sat;
      logic                  south;
   } ntlp_snap_type;

endpackage

[hw/rtl/ntlp_emit.sv]
module ntlp_emit import ntlp_pkg::*; #(
   parameter int MIN_FRAC_DIGITS = MINUTE_FRACTION_DIGITS
) (
   input  ntlp_snap_type                       snap,
   input  logic [MIN_FRAC_DIGITS:0][Q_W-1:0]   lane_q,
   input  logic [MIN_FRAC_DIGITS:0][R_W-1:0]   lane_r,
   output logic [UTC_W-1:0]                    utc_thousandths,
   output logic signed [LAT_W-1:0]             latitude_e7
);

   localparam int LANE_SEL_W = $clog2(MIN_FRAC_DIGITS + 1);

   logic [1:0]            time_frac;
   logic [9:0]            time_scale;
   logic [37:0]           time_full;
   logic [FRAC_W-1:0]     min_frac;
   logic [LANE_SEL_W-1:0] lane_sel;
   logic [Q_W-1:0]        minute_q;
   logic                  round_up;
   logic [31:0]           mag;
   logic [LAT_W-1:0]      mag_sat;
   logic [LAT_W-1:0]      lat_bits;

   assign time_frac = (snap.frac_seen < 3'd3) ? snap.frac_seen[1:0] : 2'd3;
   assign time_scale = POW10_3[2'd3 - time_frac];
   assign time_full = 38'(snap.time_acc) * 38'(time_scale);
   assign utc_thousandths = (time_full > 38'(TIME_MAX)) ? TIME_MAX : time_full[UTC_W-1:0];

   assign min_frac = (snap.frac_seen < FRAC_W'(MIN_FRAC_DIGITS)) ?
                     snap.frac_seen : FRAC_W'(MIN_FRAC_DIGITS);
   assign lane_sel = min_frac[LANE_SEL_W-1:0];
   assign minute_q = snap.min_sat ? SAT_Q[min_frac] : lane_q[lane_sel];
   assign round_up = !snap.min_sat && (lane_r[lane_sel] >= 6'd30);

   assign mag = 32'(snap.deg) * 32'(DEG_SCALE) + 32'(minute_q) + 32'(round_up);
   assign mag_sat = (mag > 32'(LAT_MAX)) ? LAT_MAX : mag[LAT_W-1:0];
   assign lat_bits = snap.south ? (~mag_sat + 31'd1) : mag_sat;
   assign latitude_e7 = $signed(lat_bits);

endmodule

[hw/rtl/nmea_time_latitude_parser.sv]
// Parses NMEA time and latitude fields from a stream of ASCII characters, one character per
// item. '$' restarts a sentence, ',' moves to the next field, and '*' delivers one result
// holding the UTC time in thousandths of a second and the latitude in 1e-7 degrees, negative
// when the hemisphere field starts with 'S'. A character can be accepted in every cycle while
// no result waits stalled, and the result of '*' appears on the next cycle. This rate rests on
// the per-character state update, which keeps the minutes already divided by 60 as a
// running quotient and remainder for each possible fraction length, so the conversion at '*'
// is one multiply and add. Input is stalled only while a result waits and is itself stalled.
module nmea_time_latitude_parser import ntlp_pkg::*; #(
   parameter int MIN_FRAC_DIGITS = MINUTE_FRACTION_DIGITS,
   parameter int FIELD_CHARS = FIELD_MAX_CHARS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHAR_W-1:0]       req_char_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [UTC_W-1:0]        rsp_utc_thousandths,
   output logic signed [LAT_W-1:0] rsp_latitude_e7,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [FIELD_W-1:0]      csr_data
);

   typedef struct packed {
      logic [3:0]     quo;
      logic [R_W-1:0] rem;
   } div60_type;

   function automatic div60_type div60_small(input logic [9:0] value);
      div60_type res;
      res.quo = '0;
      for (int k = 1; k < 16; k++) begin
         if (value >= 10'(k * 60)) begin
            res.quo = 4'(k);
         end
      end
      res.rem = R_W'(value - 10'(res.quo) * 10'd60);
      return res;
   endfunction

   logic [FIELD_W-1:0]                  time_idx_ff, time_idx_in;
   logic [FIELD_W-1:0]                  lat_idx_ff, lat_idx_in;
   logic [FIELD_W-1:0]                  field_ff, field_in;
   logic [FIELD_W-1:0]                  pos_ff, pos_in;
   logic [TIME_ACC_W-1:0]               time_acc_ff, time_acc_in;
   logic                                point_ff, point_in;
   logic [FRAC_W-1:0]                   frac_ff, frac_in;
   logic [DEG_W-1:0]                    deg_ff, deg_in;
   logic [MIN_W-1:0]                    min_ff, min_in;
   logic                                min_sat_ff, min_sat_in;
   logic                                south_ff, south_in;
   logic [MIN_FRAC_DIGITS:0][Q_W-1:0]   lane_q_ff, lane_q_in;
   logic [MIN_FRAC_DIGITS:0][R_W-1:0]   lane_r_ff, lane_r_in;
   logic [MIN_FRAC_DIGITS:0][Q_W-1:0]   lane_q_upd;
   logic [MIN_FRAC_DIGITS:0][R_W-1:0]   lane_r_upd;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [UTC_W-1:0]                    utc_ff, utc_in;
   logic signed [LAT_W-1:0]             lat_ff, lat_in;

   logic                        req_accept;
   logic                        parse_clear;
   logic                        emit_now;
   logic                        min_take;
   logic                        is_time;
   logic                        is_lat;
   logic                        is_digit;
   logic [DIGIT_W-1:0]          digit_val;
   logic                        lat_deg;
   logic                        lat_min;
   logic                        num_field;
   logic [31:0]                 time_sum;
   logic [TIME_ACC_W-1:0]       time_app;
   logic [23:0]                 min_sum;
   logic                        min_ovf;
   logic [10:0]                 deg_sum;
   logic [DEG_W-1:0]            deg_app;
   ntlp_snap_type               snap;
   logic [UTC_W-1:0]            utc_calc;
   logic signed [LAT_W-1:0]     lat_calc;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign parse_clear = req_accept && (req_char_in == CH_DOLLAR || req_char_in == CH_STAR);
   assign emit_now = req_accept && (req_char_in == CH_STAR);
   assign csr_ready = 1'b1;

   assign is_time = field_ff == time_idx_ff;
   assign is_lat = field_ff == lat_idx_ff;
   assign is_digit = (req_char_in >= CH_ZERO) && (req_char_in <= CH_NINE);
   assign digit_val = is_digit ? DIGIT_W'(req_char_in - CH_ZERO) : '0;
   assign lat_deg = is_lat && (pos_ff < 4'd2);
   assign lat_min = is_lat && (pos_ff >= 4'd2);
   assign num_field = is_time || lat_min;

   assign time_sum = 32'(time_acc_ff) * 32'd10 + 32'(digit_val);
   assign time_app = (time_sum > 32'(TIME_ACC_MAX)) ? TIME_ACC_MAX : time_sum[TIME_ACC_W-1:0];
   assign min_sum = 24'(min_ff) * 24'd10 + 24'(digit_val);
   assign min_ovf = min_sum > 24'(MIN_ACC_MAX);
   assign deg_sum = 11'(deg_ff) * 11'd10 + 11'(digit_val);
   assign deg_app = (deg_sum > 11'(DEG_MAX)) ? DEG_MAX : deg_sum[DEG_W-1:0];

   for (genvar j = 0; j <= MIN_FRAC_DIGITS; j++) begin : g_lane
      logic [9:0]  rem_mix;
      div60_type   rem_div;
      logic [33:0] q_sum;

      assign rem_mix = 10'(lane_r_ff[j]) * 10'd10 + 10'(digit_val) * 10'(LANE_R[j]);
      assign rem_div = div60_small(rem_mix);
      assign q_sum = 34'(lane_q_ff[j]) * 34'd10 + 34'(digit_val) * 34'(LANE_Q[j]) +
                     34'(rem_div.quo);
      assign lane_q_upd[j] = (q_sum > 34'(Q_MAX)) ? Q_MAX : q_sum[Q_W-1:0];
      assign lane_r_upd[j] = rem_div.rem;
   end

   always_comb begin
      time_idx_in = time_idx_ff;
      lat_idx_in = lat_idx_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_TIME_FIELD: time_idx_in = csr_data;
            CSR_LAT_FIELD:  lat_idx_in = csr_data;
         endcase
      end
   end

   always_comb begin
      field_in = field_ff;
      pos_in = pos_ff;
      time_acc_in = time_acc_ff;
      point_in = point_ff;
      frac_in = frac_ff;
      deg_in = deg_ff;
      south_in = south_ff;
      min_take = 1'b0;
      if (req_accept) begin
         priority if (parse_clear) begin
            field_in = '0;
            pos_in = '0;
            time_acc_in = '0;
            point_in = 1'b0;
            frac_in = '0;
            deg_in = '0;
            south_in = 1'b0;
         end else if (req_char_in == CH_COMMA) begin
            field_in = (field_ff == FIELD_LAST) ? field_ff : field_ff + 4'd1;
            pos_in = '0;
            point_in = 1'b0;
            frac_in = '0;
         end else if (pos_ff < FIELD_W'(FIELD_CHARS)) begin
            pos_in = pos_ff + 4'd1;
            if (field_ff == FIELD_W'(lat_idx_ff + 4'd1) && lat_idx_ff != FIELD_LAST &&
                pos_ff == '0) begin
               south_in = req_char_in == CH_SOUTH;
            end
            if (lat_deg && is_digit) begin
               deg_in = deg_app;
            end
            if (req_char_in == CH_DOT && num_field) begin
               point_in = 1'b1;
            end else if (is_digit && num_field) begin
               if (!point_ff) begin
                  if (is_time) begin
                     time_acc_in = time_app;
                  end
                  min_take = lat_min;
               end else begin
                  if (is_time && frac_ff < 3'd3) begin
                     time_acc_in = time_app;
                  end
                  min_take = lat_min && (frac_ff < FRAC_W'(MIN_FRAC_DIGITS));
                  if (frac_ff != '1) begin
                     frac_in = frac_ff + 3'd1;
                  end
               end
            end
         end else begin
            pos_in = pos_ff;
         end
      end
   end

   always_comb begin
      min_in = min_ff;
      min_sat_in = min_sat_ff;
      lane_q_in = lane_q_ff;
      lane_r_in = lane_r_ff;
      if (parse_clear) begin
         min_in = '0;
         min_sat_in = 1'b0;
         lane_q_in = '0;
         lane_r_in = '0;
      end else if (min_take) begin
         min_in = min_ovf ? MIN_ACC_MAX : min_sum[MIN_W-1:0];
         min_sat_in = min_sat_ff || min_ovf;
         lane_q_in = lane_q_upd;
         lane_r_in = lane_r_upd;
      end
   end

   assign snap.time_acc = time_acc_ff;
   assign snap.frac_seen = frac_ff;
   assign snap.deg = deg_ff;
   assign snap.min_sat = min_sat_ff;
   assign snap.south = south_ff;

   ntlp_emit #(
      .MIN_FRAC_DIGITS (MIN_FRAC_DIGITS)
   ) u_emit (
      .snap            (snap),
      .lane_q          (lane_q_ff),
      .lane_r          (lane_r_ff),
      .utc_thousandths (utc_calc),
      .latitude_e7     (lat_calc)
   );

   assign rsp_valid_in = emit_now || (rsp_valid_ff && rsp_stall);
   assign utc_in = emit_now ? utc_calc : utc_ff;
   assign lat_in = emit_now ? lat_calc : lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_idx_ff <= 4'd1;
         lat_idx_ff <= 4'd2;
         field_ff <= '0;
         pos_ff <= '0;
         time_acc_ff <= '0;
         point_ff <= 1'b0;
         frac_ff <= '0;
         deg_ff <= '0;
         min_ff <= '0;
         min_sat_ff <= 1'b0;
         south_ff <= 1'b0;
         lane_q_ff <= '0;
         lane_r_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_idx_ff <= time_idx_in;
         lat_idx_ff <= lat_idx_in;
         field_ff <= field_in;
         pos_ff <= pos_in;
         time_acc_ff <= time_acc_in;
         point_ff <= point_in;
         frac_ff <= frac_in;
         deg_ff <= deg_in;
         min_ff <= min_in;
         min_sat_ff <= min_sat_in;
         south_ff <= south_in;
         lane_q_ff <= lane_q_in;
         lane_r_ff <= lane_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      utc_ff <= utc_in;
      lat_ff <= lat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_utc_thousandths = utc_ff;
   assign rsp_latitude_e7 = lat_ff;

   a_star_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_char_in == CH_STAR) |=> rsp_valid)
      else $error("end of sentence did not produce a result");

   a_blocked_output_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while a result is blocked");

   a_latitude_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_latitude_e7 <= 31'sd900000000 &&
                     rsp_latitude_e7 >= -31'sd900000000))
      else $error("latitude out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_utc_thousandths <= TIME_MAX))
      else $error("time out of range");

endmodule

[test/tb.sv]
module tb;
   import ntlp_pkg::*;

   typedef struct {
      logic [UTC_W-1:0]        utc;
      logic signed [LAT_W-1:0] lat;
   } fix_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CHARS_PER_PHASE = 150;
   localparam int FIXES_PER_PHASE = 4;
   localparam int PHASES = 7;
   localparam logic [FIELD_W-1:0] TIME_SEL [PHASES] = '{
      4'd1, 4'd0, 4'd15, 4'd5, 4'd0, 4'd14, 4'd1
   };
   localparam logic [FIELD_W-1:0] LAT_SEL [PHASES] = '{
      4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd3, 4'd2
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CHAR_W-1:0]       req_char_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [UTC_W-1:0]        rsp_utc_thousandths;
   logic signed [LAT_W-1:0] rsp_latitude_e7;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_reg_type             csr_index = CSR_TIME_FIELD;
   logic [FIELD_W-1:0]      csr_data = '0;

   nmea_time_latitude_parser dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sentence parser state mirrored from the block.
   logic [FIELD_W-1:0]    time_fld = 4'd1;
   logic [FIELD_W-1:0]    lat_fld = 4'd2;
   logic [FIELD_W-1:0]    fld_no;
   logic [FIELD_W-1:0]    pos_in_fld;
   logic [TIME_ACC_W-1:0] utc_acc;
   logic                  frac_mode;
   logic [FRAC_W-1:0]     frac_cnt;
   logic [DEG_W-1:0]      deg_acc;
   logic [MIN_W-1:0]      min_acc;
   logic                  is_south;

   logic [CHAR_W-1:0] nmea_chars [$];
   fix_type           pending_fixes [$];
   fix_type           want;
   int                errors = 0;
   int                queued_chars = 0;
   int                queued_fixes = 0;
   bit                noise_on = 1'b0;
   int                gap_left = 0;
   int                burst_left = 1;
   logic [31:0]       cycle_count = '0;
   logic [31:0]       stall_tick = '0;

   function automatic logic [63:0] ten_to(int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic logic [63:0] append_digit(logic [63:0] acc, logic [3:0] d,
                                                logic [63:0] cap);
      logic [63:0] v;
      v = acc * 64'd10 + 64'(d);
      return (v > cap) ? cap : v;
   endfunction

   function automatic void clear_sentence();
      fld_no = '0;
      pos_in_fld = '0;
      utc_acc = '0;
      frac_mode = 1'b0;
      frac_cnt = '0;
      deg_acc = '0;
      min_acc = '0;
      is_south = 1'b0;
   endfunction

   function automatic fix_type fix_from_fields();
      fix_type     r;
      int          ft;
      int          fm;
      logic [63:0] t;
      logic [63:0] dv;
      logic [63:0] mag;
      logic [63:0] signed_lat;
      ft = (frac_cnt < 3'd3) ? int'(frac_cnt) : 3;
      fm = (int'(frac_cnt) < MINUTE_FRACTION_DIGITS) ? int'(frac_cnt) : MINUTE_FRACTION_DIGITS;
      t = 64'(utc_acc) * ten_to(3 - ft);
      dv = 64'd60 * ten_to(fm);
      mag = 64'(deg_acc) * 64'd10000000 + (64'(min_acc) * 64'd10000000 + dv / 64'd2) / dv;
      if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
      if (mag > 64'(LAT_MAX)) mag = 64'(LAT_MAX);
      signed_lat = is_south ? (64'd0 - mag) : mag;
      r.utc = t[UTC_W-1:0];
      r.lat = signed_lat[LAT_W-1:0];
      return r;
   endfunction

   function automatic void take_field_char(logic [CHAR_W-1:0] c);
      logic       in_time;
      logic       in_lat;
      logic       dig;
      logic       lat_deg;
      logic       lat_min;
      logic [3:0] d;
      in_time = (fld_no == time_fld);
      in_lat = (fld_no == lat_fld);
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      d = dig ? 4'(c - CH_ZERO) : 4'd0;
      lat_deg = in_lat && (pos_in_fld < 4'd2);
      lat_min = in_lat && (pos_in_fld >= 4'd2);
      if (lat_fld != FIELD_LAST && fld_no == 4'(lat_fld + 4'd1) && pos_in_fld == 4'd0)
         is_south = (c == CH_SOUTH);
      if (lat_deg && dig) deg_acc = 7'(append_digit(64'(deg_acc), d, 64'(DEG_MAX)));
      if (c == CH_DOT && (in_time || lat_min)) begin
         frac_mode = 1'b1;
      end else if (dig && (in_time || lat_min)) begin
         if (!frac_mode) begin
            if (in_time) utc_acc = 28'(append_digit(64'(utc_acc), d, 64'(TIME_ACC_MAX)));
            if (lat_min) min_acc = 20'(append_digit(64'(min_acc), d, 64'(MIN_ACC_MAX)));
         end else begin
            if (in_time && frac_cnt < 3'd3)
               utc_acc = 28'(append_digit(64'(utc_acc), d, 64'(TIME_ACC_MAX)));
            if (lat_min && int'(frac_cnt) < MINUTE_FRACTION_DIGITS)
               min_acc = 20'(append_digit(64'(min_acc), d, 64'(MIN_ACC_MAX)));
            if (frac_cnt < 3'd7) frac_cnt = frac_cnt + 3'd1;
         end
      end
   endfunction

   function automatic void track_char(logic [CHAR_W-1:0] c);
      if (c == CH_DOLLAR) begin
         clear_sentence();
      end else if (c == CH_STAR) begin
         pending_fixes.push_back(fix_from_fields());
         clear_sentence();
      end else if (c == CH_COMMA) begin
         if (fld_no != FIELD_LAST) fld_no = fld_no + 4'd1;
         pos_in_fld = '0;
         frac_mode = 1'b0;
         frac_cnt = '0;
      end else if (int'(pos_in_fld) < FIELD_MAX_CHARS && pos_in_fld < 4'd15) begin
         take_field_char(c);
         pos_in_fld = pos_in_fld + 4'd1;
      end
   endfunction

   function automatic void push_char(logic [CHAR_W-1:0] c);
      nmea_chars.push_back(c);
      queued_chars++;
      if (c == CH_STAR) queued_fixes++;
      if (noise_on && $urandom_range(0, 24) == 0) begin
         nmea_chars.push_back(8'($urandom_range(0, 255)));
         queued_chars++;
      end
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   function automatic void push_digits(int n);
      repeat (n) push_char(8'($urandom_range(CH_ZERO, CH_NINE)));
   endfunction

   function automatic void push_two(int v);
      push_char(8'(CH_ZERO + v / 10));
      push_char(8'(CH_ZERO + v % 10));
   endfunction

   function automatic logic [CHAR_W-1:0] stray_char();
      logic [CHAR_W-1:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
      return c;
   endfunction

   function automatic void push_mixed(int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: push_digits(1);
            1: push_char(CH_DOT);
            default: push_char(stray_char());
         endcase
      end
   endfunction

   function automatic void push_time_field();
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            push_two($urandom_range(0, 23));
            push_two($urandom_range(0, 59));
            push_two($urandom_range(0, 59));
            push_char(CH_DOT);
            push_digits($urandom_range(0, 4));
         end
         3: push_digits($urandom_range(0, 12));
         4: begin
            push_digits($urandom_range(0, 3));
            push_char(CH_DOT);
            push_digits($urandom_range(0, 3));
            push_char(CH_DOT);
            push_digits($urandom_range(0, 3));
         end
         default: push_mixed($urandom_range(1, 12));
      endcase
   endfunction

   function automatic void push_lat_field();
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            push_two($urandom_range(0, 89));
            push_two($urandom_range(0, 59));
            push_char(CH_DOT);
            push_digits($urandom_range(0, 6));
         end
         3: push_digits($urandom_range(0, 11));
         4: begin
            push_digits($urandom_range(0, 3));
            push_char(CH_DOT);
            push_digits($urandom_range(0, 7));
         end
         default: push_mixed($urandom_range(1, 12));
      endcase
   endfunction

   function automatic void push_hemisphere();
      case ($urandom_range(0, 5))
         0, 1: push_char(CH_SOUTH);
         2, 3: push_char("N");
         4: ;
         default: begin
            push_char(stray_char());
            push_char(CH_SOUTH);
         end
      endcase
   endfunction

   function automatic void push_sentence();
      string hex_digits;
      int    tf;
      int    lf;
      int    nf;
      hex_digits = "0123456789ABCDEF";
      tf = int'(time_fld);
      lf = int'(lat_fld);
      nf = ((tf > lf + 1) ? tf : lf + 1) + 1 + $urandom_range(0, 2);
      noise_on = ($urandom_range(0, 7) == 0);
      push_char(CH_DOLLAR);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) push_char(CH_COMMA);
         if (f == tf) push_time_field();
         else if (f == lf) push_lat_field();
         else if (f == lf + 1) push_hemisphere();
         else if (f == 0) push_text("GPGGA");
         else push_mixed($urandom_range(0, 3));
      end
      if ($urandom_range(0, 15) != 0) begin
         push_char(CH_STAR);
         push_char(hex_digits[$urandom_range(0, 15)]);
         push_char(hex_digits[$urandom_range(0, 15)]);
         if ($urandom_range(0, 1)) begin
            push_char(8'h0D);
            push_char(8'h0A);
         end
      end
      noise_on = 1'b0;
   endfunction

   task automatic settle();
      do @(negedge clock);
      while (nmea_chars.size() != 0 || req_valid || pending_fixes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_field_reg(csr_reg_type idx, logic [FIELD_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TIME_FIELD) time_fld = val;
      else lat_fld = val;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_char(req_char_in);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (nmea_chars.size() > 0) begin
               req_valid <= 1'b1;
               req_char_in <= nmea_chars.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      stall_tick <= stall_tick + 32'd1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_fixes.size() == 0) begin
               $error("unexpected result: utc_thousandths %0d latitude_e7 %0d",
                      rsp_utc_thousandths, rsp_latitude_e7);
               errors++;
            end else begin
               want = pending_fixes.pop_front();
               if (rsp_utc_thousandths !== want.utc) begin
                  $error("utc_thousandths: expected %0d, got %0d",
                         want.utc, rsp_utc_thousandths);
                  errors++;
               end
               if (rsp_latitude_e7 !== want.lat) begin
                  $error("latitude_e7: expected %0d, got %0d", want.lat, rsp_latitude_e7);
                  errors++;
               end
            end
         end
         case (stall_tick[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= 1'($urandom_range(0, 1));
            2'd2: rsp_stall <= (stall_tick[3:0] < 4'd11);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int base_chars;
      int base_fixes;
      clear_sentence();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      push_text("$,235959.999,9000.0000,S*");
      push_text("$,9.99999,00.123456,S*");
      push_text("*");
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            if ($urandom_range(0, 1)) begin
               write_field_reg(CSR_TIME_FIELD, TIME_SEL[p]);
               write_field_reg(CSR_LAT_FIELD, LAT_SEL[p]);
            end else begin
               write_field_reg(CSR_LAT_FIELD, LAT_SEL[p]);
               write_field_reg(CSR_TIME_FIELD, TIME_SEL[p]);
            end
         end
         base_chars = queued_chars;
         base_fixes = queued_fixes;
         while (queued_chars - base_chars < CHARS_PER_PHASE ||
                queued_fixes - base_fixes < FIXES_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 10)) push_char(8'($urandom_range(0, 255)));
            else
               push_sentence();
         end
      end
      settle();
      if (pending_fixes.size() != 0) begin
         $error("%0d expected results never arrived", pending_fixes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
